FILE: design/itcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itcf_pkg
// Shared constants and tables of the tilt complementary filter.
// ----------------------------------------------------------------------------
package itcf_pkg;

	localparam int ANGLE_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 24;

	localparam logic [16:0] BLEND_RESET = 17'd64225;
	localparam logic [15:0] GAIN_RESET  = 16'd0;
	localparam logic [16:0] ALPHA_ONE   = 17'd65536;

	localparam logic [1:0] REG_BLEND = 2'd0;
	localparam logic [1:0] REG_GAIN  = 2'd1;

	function automatic logic [29:0] atan_turn32(input logic [4:0] i);
		logic [29:0] r;
		begin
			case (i)
				5'd0:    r = 30'd536870912;
				5'd1:    r = 30'd316933406;
				5'd2:    r = 30'd167458907;
				5'd3:    r = 30'd85004756;
				5'd4:    r = 30'd42667331;
				5'd5:    r = 30'd21354465;
				5'd6:    r = 30'd10679838;
				5'd7:    r = 30'd5340245;
				5'd8:    r = 30'd2670163;
				5'd9:    r = 30'd1335087;
				5'd10:   r = 30'd667544;
				5'd11:   r = 30'd333772;
				5'd12:   r = 30'd166886;
				5'd13:   r = 30'd83443;
				5'd14:   r = 30'd41722;
				5'd15:   r = 30'd20861;
				5'd16:   r = 30'd10430;
				5'd17:   r = 30'd5215;
				5'd18:   r = 30'd2608;
				5'd19:   r = 30'd1304;
				5'd20:   r = 30'd652;
				5'd21:   r = 30'd326;
				5'd22:   r = 30'd163;
				5'd23:   r = 30'd81;
				default: r = 30'd0;
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

FILE: design/itcf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itcf_if
// Valid/ready channels: sample in, tilt out, register write.
// ----------------------------------------------------------------------------
interface itcf_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] accel_x;
	logic [15:0] accel_y;
	logic [15:0] accel_z;
	logic [15:0] gyro_x;
	logic [15:0] gyro_y;
	modport source (output valid, kind, accel_x, accel_y, accel_z, gyro_x, gyro_y,
		input ready);
	modport sink (input valid, kind, accel_x, accel_y, accel_z, gyro_x, gyro_y,
		output ready);
endinterface

interface itcf_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] tilt_x;
	logic [15:0] tilt_y;
	modport source (output valid, tilt_x, tilt_y, input ready);
	modport sink (input valid, tilt_x, tilt_y, output ready);
endinterface

interface itcf_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [16:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: design/itcf_angle.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itcf_angle
// Accelerometer angle atan2(a, sqrt(b^2+c^2)) folded by sign of Z: one
// multiply-accumulate for the squares, bit-pair square root, shared CORDIC.
// ----------------------------------------------------------------------------
module itcf_angle
	import itcf_pkg::*;
#(
	parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic signed [15:0]    a,
	input  wire logic signed [15:0]    b,
	input  wire logic signed [15:0]    c,
	input  wire logic                  z_neg,
	output logic                       done,
	output logic [ANGLE_BITS-1:0]      angle
);

	localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam int SHIFT = 32 - ANGLE_BITS;
	localparam logic [31:0] ROUND = 32'd1 << (SHIFT - 1);
	localparam logic [31:0] HALF  = 32'd1 << (ANGLE_BITS - 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SQ   = 5'b00010,
		ST_ROOT = 5'b00100,
		ST_ROT  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [4:0]         cnt_q;
	logic [63:0]        rem_q;
	logic [31:0]        root_q;
	logic [65:0]        rad_q;
	logic signed [57:0] x_q;
	logic signed [57:0] y_q;
	logic signed [33:0] z_q;
	logic signed [15:0] a_q, b_q, c_q;
	logic               zneg_q;
	logic               azero_q;

	logic [33:0] trial;
	logic [63:0] rem_sh;
	logic        take;
	logic signed [57:0] dx, dy;
	logic signed [30:0] at;
	logic signed [31:0] zr;
	logic signed [31:0] ang;
	logic signed [15:0] sq_in;
	logic [31:0] sq_b;

	always_comb begin
		sq_in  = cnt_q[0] ? c_q : b_q;
		sq_b   = 32'(32'(sq_in) * 32'(sq_in));
		rem_sh = {rem_q[61:0], rad_q[65:64]};
		trial  = {root_q, 2'b01};
		take   = {30'd0, rem_sh} >= {30'd0, trial};
		dx     = y_q >>> cnt_q;
		dy     = x_q >>> cnt_q;
		at     = $signed({1'b0, atan_turn32(cnt_q)});
		zr     = 32'((z_q + $signed(34'(ROUND))) >>> SHIFT);
		if (azero_q) ang = 32'sd0;
		else ang = zr;
		if (zneg_q) ang = $signed(HALF) - ang;
		else if (ang < 0) ang = ang + $signed(32'd1 << ANGLE_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (start) begin
					state_q <= ST_SQ;
					cnt_q   <= '0;
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q[0]) begin
						state_q <= ST_ROOT;
						cnt_q   <= '0;
					end
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_ROT;
						cnt_q   <= '0;
					end
				end
				ST_ROT: begin
					cnt_q <= cnt_q + 5'd1;
					if (32'(cnt_q) == STEPS - 1) state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
					done    <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				a_q     <= a;
				b_q     <= b;
				c_q     <= c;
				zneg_q  <= z_neg;
				azero_q <= (a == 16'sd0);
				rad_q   <= '0;
				rem_q   <= '0;
				root_q  <= '0;
			end
			ST_SQ: begin
				rad_q <= rad_q + {sq_b, 34'd0};
			end
			ST_ROOT: begin
				rad_q <= {rad_q[63:0], 2'b00};
				if (take) begin
					rem_q  <= 64'(rem_sh - 64'(trial));
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[30:0], 1'b0};
				end
				if (cnt_q == 5'd31) begin
					x_q <= 58'(take ? {root_q[30:0], 1'b1} : {root_q[30:0], 1'b0}) <<< 8;
					y_q <= 58'(a_q) <<< 24;
					z_q <= '0;
				end
			end
			ST_ROT: begin
				if (y_q >= 0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + 34'(at);
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - 34'(at);
				end
			end
			ST_FIN: angle <= ang[ANGLE_BITS-1:0];
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: design/imu_tilt_complementary_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter
// Two-axis tilt complementary filter over accelerometer and gyro samples.
//
// Channels: in (kind, accel_x/y/z, gyro_x/y), out (tilt_x, tilt_y) and cfg
// (index 0 blend_weight, index 1 step_gain; other indexes dropped). Each
// accepted sample item yields one result item.
// From acceptance to out.valid the two accelerometer angles run one after
// the other through one angle unit (start, squaring of b and c, bit-pair
// square root, CORDIC_STEPS rotations, rounding, done), then an update item
// goes through the blend arithmetic per axis in ST_MUL1, ST_MUL2 and ST_NEXT.
// One item is in work at a time; in.ready is low from acceptance until the
// result is taken, so the next item is not accepted before then.
// Reset clears both kept angles and loads the register defaults.
// A stalled receiver holds out.valid and the result until it is taken.
// ----------------------------------------------------------------------------
module imu_tilt_complementary_filter
	import itcf_pkg::*;
#(
	parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	itcf_in_if.sink   in,
	itcf_out_if.source out,
	itcf_cfg_if.sink  cfg
);

	localparam int AB = ANGLE_BITS;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_ANGX = 7'b0000010,
		ST_ANGY = 7'b0000100,
		ST_MUL1 = 7'b0001000,
		ST_MUL2 = 7'b0010000,
		ST_NEXT = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t            state_q;
	logic              axis_q;
	logic [16:0]       blend_q;
	logic [15:0]       gain_q;
	logic [AB-1:0]     fx_q, fy_q;
	logic [AB-1:0]     accx_q, accy_q;
	logic              kind_q;
	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q;
	logic signed [AB+24:0] gq_q;
	logic signed [AB+44:0] acc_sum_q;

	logic              ang_start, ang_done;
	logic [AB-1:0]     ang;
	logic signed [15:0] ua, ub;

	logic [16:0]       alpha;
	logic signed [AB+1:0] kept_adj;
	logic [AB-1:0]     kept, acc;
	logic signed [16:0] omega;
	logic signed [AB+44:0] res;

	assign alpha = (blend_q > ALPHA_ONE) ? ALPHA_ONE : blend_q;
	assign ua = axis_q ? ay_q : ax_q;
	assign ub = axis_q ? ax_q : ay_q;
	assign ang_start = (state_q == ST_ANGX) || (state_q == ST_ANGY);

	itcf_angle #(.ANGLE_BITS(AB), .CORDIC_STEPS(CORDIC_STEPS)) u_angle (
		.clk(clk), .arst_n(arst_n), .start(ang_start && !ang_done),
		.a(ua), .b(ub), .c(az_q), .z_neg(az_q < 16'sd0),
		.done(ang_done), .angle(ang)
	);

	always_comb begin
		kept  = axis_q ? fy_q : fx_q;
		acc   = axis_q ? accy_q : accx_q;
		omega = axis_q ? 17'(gx_q) : -17'(gy_q);
		if ({2'b00, kept} > {2'b00, acc} + (AB+2)'(1 << (AB-1)))
			kept_adj = $signed({2'b00, kept}) - $signed((AB+2)'(1 << AB));
		else if ({2'b00, acc} > {2'b00, kept} + (AB+2)'(1 << (AB-1)))
			kept_adj = $signed({2'b00, kept}) + $signed((AB+2)'(1 << AB));
		else
			kept_adj = $signed({2'b00, kept});
		res = (acc_sum_q + (AB+45)'(64'sd1 <<< 31)) >>> 32;
	end

	assign in.ready  = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out.valid = (state_q == ST_OUT);
	assign out.tilt_x = 16'(fx_q);
	assign out.tilt_y = 16'(fy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= 1'b0;
			blend_q <= BLEND_RESET;
			gain_q  <= GAIN_RESET;
			fx_q    <= '0;
			fy_q    <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_BLEND: blend_q <= cfg.data;
					REG_GAIN:  gain_q  <= cfg.data[15:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: if (in.valid) begin
					state_q <= ST_ANGX;
					axis_q  <= 1'b0;
				end
				ST_ANGX: if (ang_done) begin
					state_q <= ST_ANGY;
					axis_q  <= 1'b1;
				end
				ST_ANGY: if (ang_done) begin
					axis_q <= 1'b0;
					if (kind_q) state_q <= ST_MUL1;
					else begin
						fx_q    <= accx_q;
						fy_q    <= ang;
						state_q <= ST_OUT;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_NEXT;
				ST_NEXT: begin
					if (axis_q) begin
						fy_q    <= res[AB-1:0];
						state_q <= ST_OUT;
					end else begin
						fx_q    <= res[AB-1:0];
						axis_q  <= 1'b1;
						state_q <= ST_MUL1;
					end
				end
				ST_OUT: if (out.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in.valid) begin
			kind_q <= in.kind;
			ax_q   <= in.accel_x;
			ay_q   <= in.accel_y;
			az_q   <= in.accel_z;
			gx_q   <= in.gyro_x;
			gy_q   <= in.gyro_y;
		end
		if (state_q == ST_ANGX && ang_done) accx_q <= ang;
		if (state_q == ST_ANGY && ang_done) accy_q <= ang;
		if (state_q == ST_MUL1) begin
			gq_q <= ((AB+25)'(kept_adj) <<< 16) +
				(AB+25)'(omega) * (AB+25)'($signed({1'b0, gain_q}));
			acc_sum_q <= ((AB+45)'($signed({1'b0, 17'(ALPHA_ONE - alpha)})) *
				(AB+45)'($signed({1'b0, acc}))) <<< 16;
		end
		if (state_q == ST_MUL2)
			acc_sum_q <= acc_sum_q +
				(AB+45)'($signed({1'b0, alpha})) * (AB+45)'(gq_q);
	end

	property p_busy_not_ready;
		@(posedge clk) disable iff (!arst_n)
			(state_q != ST_IDLE) |-> !in.ready;
	endproperty
	a_busy_not_ready: assert property (p_busy_not_ready) else $error("ready while busy");

	property p_out_holds;
		@(posedge clk) disable iff (!arst_n)
			(out.valid && !out.ready) |=> (out.valid && $stable(fx_q) && $stable(fy_q));
	endproperty
	a_out_holds: assert property (p_out_holds) else $error("result lost under stall");

	property p_accept_starts;
		@(posedge clk) disable iff (!arst_n)
			(in.valid && in.ready) |=> (state_q == ST_ANGX);
	endproperty
	a_accept_starts: assert property (p_accept_starts) else $error("accept did not start");

endmodule
`default_nettype wire
